[design/rsit_pkg.sv]
package rsit_pkg;

  localparam int unsigned CW = 34;
  localparam int unsigned PW = 35;
  localparam int unsigned DW = 36;
  localparam int unsigned TOLW = 31;
  localparam int unsigned SQW = 2 * TOLW;
  localparam int unsigned PROJ_STAGES = 10;

  typedef logic signed [CW-1:0] edge_t;
  typedef logic signed [PW-1:0] pnt_t;

  typedef struct packed {
    logic signed [31:0] rect_left_x;
    logic signed [31:0] rect_bottom_y;
    logic [30:0]        rect_width;
    logic [30:0]        rect_height;
    logic signed [31:0] seg_a_x;
    logic signed [31:0] seg_a_y;
    logic signed [31:0] seg_b_x;
    logic signed [31:0] seg_b_y;
  } in_t;

  typedef struct packed {
    logic hit;
    logic degenerate;
  } out_t;

  // distance from p to the interval [lo, hi] along one axis
  function automatic logic [DW-1:0] axis_dist(pnt_t p, edge_t lo, edge_t hi);
    logic signed [DW-1:0] diff;
    diff = '0;
    if (p < lo) begin
      diff = DW'(lo) - DW'(p);
    end else if (p > hi) begin
      diff = DW'(p) - DW'(hi);
    end
    return diff;
  endfunction

  function automatic logic between(pnt_t e0, pnt_t e1, pnt_t p);
    if (e0 <= e1) begin
      return (e0 <= p) && (p <= e1);
    end
    return (e1 <= p) && (p <= e0);
  endfunction

endpackage

[design/rect_segment_intersect_test.sv]
// Segment versus axis-aligned rectangle contact test with a tolerance margin.
// One query is taken per cycle while the output is not stalled, and one result
// (hit, degenerate) leaves per query, in order. The projection divider resolves
// one quotient bit per stage. A stalled output freezes the whole pipeline.
// A tolerance write goes to tol_q, and its square is registered from tol_q
// into tol_sq_q.
module rect_segment_intersect_test #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rsit_pkg::TOLW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rsit_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rsit_pkg::out_t              out_data_o
);

  localparam int unsigned LP  = FRACTION_BITS + rsit_pkg::PROJ_STAGES;
  localparam int unsigned NST = LP + 5;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    rsit_pkg::edge_t    l;
    rsit_pkg::edge_t    r;
    rsit_pkg::edge_t    b;
    rsit_pkg::edge_t    t;
    logic               degen;
  } aux_t;

  logic en;
  logic [NST-1:0] vld_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  logic [rsit_pkg::TOLW-1:0] tol_q;
  logic [rsit_pkg::SQW-1:0]  tol_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= '0;
      tol_sq_q <= '0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      tol_sq_q <= rsit_pkg::SQW'(tol_q) * rsit_pkg::SQW'(tol_q);
    end
  end

  // stage 1: rectangle edges
  aux_t s1_d, s1_q;

  always_comb begin
    s1_d.ax    = in_data_i.seg_a_x;
    s1_d.ay    = in_data_i.seg_a_y;
    s1_d.bx    = in_data_i.seg_b_x;
    s1_d.by    = in_data_i.seg_b_y;
    s1_d.l     = rsit_pkg::CW'(in_data_i.rect_left_x);
    s1_d.b     = rsit_pkg::CW'(in_data_i.rect_bottom_y);
    s1_d.r     = rsit_pkg::CW'(in_data_i.rect_left_x) + rsit_pkg::CW'(in_data_i.rect_width);
    s1_d.t     = rsit_pkg::CW'(in_data_i.rect_bottom_y) + rsit_pkg::CW'(in_data_i.rect_height);
    s1_d.degen = (in_data_i.seg_a_x == in_data_i.seg_b_x)
              && (in_data_i.seg_a_y == in_data_i.seg_b_y);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: direction and the two opposite corners picked by slope sign
  logic signed [32:0] dx, dy;
  logic               diag;
  logic signed [32:0] s2_dx_q, s2_dy_q;
  rsit_pkg::edge_t    s2_c1x_q, s2_c1y_q, s2_c2x_q, s2_c2y_q;
  aux_t               s2_q;

  always_comb begin
    dx   = 33'(s1_q.ax) - 33'(s1_q.bx);
    dy   = 33'(s1_q.ay) - 33'(s1_q.by);
    diag = (dx > 33'sd0 && dy > 33'sd0) || (dx < 33'sd0 && dy < 33'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dx_q  <= dx;
      s2_dy_q  <= dy;
      s2_c1x_q <= diag ? s1_q.l : s1_q.r;
      s2_c1y_q <= s1_q.t;
      s2_c2x_q <= diag ? s1_q.r : s1_q.l;
      s2_c2y_q <= s1_q.b;
      s2_q     <= s1_q;
    end
  end

  rsit_pkg::pnt_t p1x, p1y, p2x, p2y;

  rsit_proj #(.FRACTION_BITS(FRACTION_BITS)) u_proj1 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_x_i (s2_q.ax),
    .a_y_i (s2_q.ay),
    .d_x_i (s2_dx_q),
    .d_y_i (s2_dy_q),
    .c_x_i (s2_c1x_q),
    .c_y_i (s2_c1y_q),
    .p_x_o (p1x),
    .p_y_o (p1y)
  );

  rsit_proj #(.FRACTION_BITS(FRACTION_BITS)) u_proj2 (
    .clk_i (clk_i),
    .en_i  (en),
    .a_x_i (s2_q.ax),
    .a_y_i (s2_q.ay),
    .d_x_i (s2_dx_q),
    .d_y_i (s2_dy_q),
    .c_x_i (s2_c2x_q),
    .c_y_i (s2_c2y_q),
    .p_x_o (p2x),
    .p_y_o (p2y)
  );

  // carry the query alongside the projection units
  aux_t dly_q [LP];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= s2_q;
      for (int k = 1; k < LP; k++) begin
        dly_q[k] <= dly_q[k-1];
      end
    end
  end

  // stage q1: per-axis distances for A, B, P1, P2 and segment box checks
  aux_t           ax_e;
  rsit_pkg::pnt_t px [4];
  rsit_pkg::pnt_t py [4];
  logic [rsit_pkg::DW-1:0] ex [4];
  logic [rsit_pkg::DW-1:0] ey [4];

  logic [rsit_pkg::TOLW-1:0] q1_ex_q [4];
  logic [rsit_pkg::TOLW-1:0] q1_ey_q [4];
  logic [3:0]                q1_small_q;
  logic [1:0]                q1_box_q;
  logic                      q1_degen_q;

  always_comb begin
    ax_e  = dly_q[LP-1];
    px[0] = rsit_pkg::PW'(ax_e.ax);
    py[0] = rsit_pkg::PW'(ax_e.ay);
    px[1] = rsit_pkg::PW'(ax_e.bx);
    py[1] = rsit_pkg::PW'(ax_e.by);
    px[2] = p1x;
    py[2] = p1y;
    px[3] = p2x;
    py[3] = p2y;
    for (int k = 0; k < 4; k++) begin
      ex[k] = rsit_pkg::axis_dist(px[k], ax_e.l, ax_e.r);
      ey[k] = rsit_pkg::axis_dist(py[k], ax_e.b, ax_e.t);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        q1_ex_q[k]    <= ex[k][rsit_pkg::TOLW-1:0];
        q1_ey_q[k]    <= ey[k][rsit_pkg::TOLW-1:0];
        q1_small_q[k] <= (ex[k] <= rsit_pkg::DW'(tol_q)) && (ey[k] <= rsit_pkg::DW'(tol_q));
      end
      for (int k = 0; k < 2; k++) begin
        q1_box_q[k] <= rsit_pkg::between(px[0], px[1], px[k+2])
                    && rsit_pkg::between(py[0], py[1], py[k+2]);
      end
      q1_degen_q <= ax_e.degen;
    end
  end

  // stage q2: squared distances
  logic [rsit_pkg::SQW-1:0] q2_sx_q [4];
  logic [rsit_pkg::SQW-1:0] q2_sy_q [4];
  logic [3:0]               q2_small_q;
  logic [1:0]               q2_box_q;
  logic                     q2_degen_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        q2_sx_q[k] <= rsit_pkg::SQW'(q1_ex_q[k]) * rsit_pkg::SQW'(q1_ex_q[k]);
        q2_sy_q[k] <= rsit_pkg::SQW'(q1_ey_q[k]) * rsit_pkg::SQW'(q1_ey_q[k]);
      end
      q2_small_q <= q1_small_q;
      q2_box_q   <= q1_box_q;
      q2_degen_q <= q1_degen_q;
    end
  end

  // stage q3: compare against tolerance squared and combine
  logic [3:0]     near;
  logic           end_hit;
  rsit_pkg::out_t res;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      near[k] = q2_small_q[k]
             && ((rsit_pkg::SQW+1)'(q2_sx_q[k]) + (rsit_pkg::SQW+1)'(q2_sy_q[k])
                 <= (rsit_pkg::SQW+1)'(tol_sq_q));
    end
    end_hit        = near[0] || near[1];
    res.hit        = end_hit || (!q2_degen_q && ((near[2] && q2_box_q[0])
                                              || (near[3] && q2_box_q[1])));
    res.degenerate = !end_hit && q2_degen_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o <= res;
    end
  end

endmodule

[design/rsit_proj.sv]
module rsit_proj #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [32:0] d_x_i,
  input  logic signed [32:0] d_y_i,
  input  rsit_pkg::edge_t    c_x_i,
  input  rsit_pkg::edge_t    c_y_i,
  output rsit_pkg::pnt_t     p_x_o,
  output rsit_pkg::pnt_t     p_y_o
);

  localparam int unsigned NDIV = FRACTION_BITS + 2;
  localparam int unsigned QW   = FRACTION_BITS + 2;
  localparam int unsigned TW   = FRACTION_BITS + 3;
  localparam int unsigned MW   = FRACTION_BITS + 36;
  localparam logic [TW-1:0] LIM_N = TW'(1) << (FRACTION_BITS + 1);
  localparam logic [TW-1:0] LIM_P = TW'(1) << FRACTION_BITS;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } ad_t;

  ad_t ad_in;
  assign ad_in = '{ax: a_x_i, ay: a_y_i, dx: d_x_i, dy: d_y_i};

  // magnitudes and signs of the dot-product operands
  logic signed [34:0] sx, sy;
  logic [33:0] p1_op_q [4];
  logic [33:0] p1_op_d [4];
  logic        p1_n1_q, p1_n2_q;
  ad_t         p1_ad_q;

  always_comb begin
    sx = 35'(c_x_i) - 35'(a_x_i);
    sy = 35'(c_y_i) - 35'(a_y_i);
    p1_op_d[0] = (sx < 0) ? 34'(-sx) : 34'(sx);
    p1_op_d[1] = (sy < 0) ? 34'(-sy) : 34'(sy);
    p1_op_d[2] = (d_x_i < 0) ? 34'(-d_x_i) : 34'(d_x_i);
    p1_op_d[3] = (d_y_i < 0) ? 34'(-d_y_i) : 34'(d_y_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_op_q <= p1_op_d;
      p1_n1_q <= (sx < 0) != (d_x_i < 0);
      p1_n2_q <= (sy < 0) != (d_y_i < 0);
      p1_ad_q <= ad_in;
    end
  end

  // partial products: sx*dx, sy*dy, dx*dx, dy*dy, each split in two halves
  logic [33:0] op_a [4];
  logic [33:0] op_b [4];
  logic [50:0] p2_lo_q [4];
  logic [50:0] p2_hi_q [4];
  logic        p2_n1_q, p2_n2_q;
  ad_t         p2_ad_q;

  always_comb begin
    op_a[0] = p1_op_q[0]; op_b[0] = p1_op_q[2];
    op_a[1] = p1_op_q[1]; op_b[1] = p1_op_q[3];
    op_a[2] = p1_op_q[2]; op_b[2] = p1_op_q[2];
    op_a[3] = p1_op_q[3]; op_b[3] = p1_op_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        p2_lo_q[k] <= 51'(op_a[k][16:0]) * 51'(op_b[k]);
        p2_hi_q[k] <= 51'(op_a[k][33:17]) * 51'(op_b[k]);
      end
      p2_n1_q <= p1_n1_q;
      p2_n2_q <= p1_n2_q;
      p2_ad_q <= p1_ad_q;
    end
  end

  logic [67:0] p3_m_q [4];
  logic        p3_n1_q, p3_n2_q;
  ad_t         p3_ad_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        p3_m_q[k] <= 68'(p2_lo_q[k]) + (68'(p2_hi_q[k]) << 17);
      end
      p3_n1_q <= p2_n1_q;
      p3_n2_q <= p2_n2_q;
      p3_ad_q <= p2_ad_q;
    end
  end

  logic signed [69:0] t1, t2;
  logic signed [69:0] p4_num_q;
  logic [67:0]        p4_den_q;
  ad_t                p4_ad_q;

  always_comb begin
    t1 = p3_n1_q ? -$signed(70'(p3_m_q[0])) : $signed(70'(p3_m_q[0]));
    t2 = p3_n2_q ? -$signed(70'(p3_m_q[1])) : $signed(70'(p3_m_q[1]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p4_num_q <= t1 + t2;
      p4_den_q <= p3_m_q[2] + p3_m_q[3];
      p4_ad_q  <= p3_ad_q;
    end
  end

  // restoring divider, one quotient bit per stage; entry 0 holds the set-up
  logic [69:0]   dv_r_q   [NDIV+1];
  logic [67:0]   dv_d_q   [NDIV+1];
  logic [QW-1:0] dv_q_q   [NDIV+1];
  logic          dv_neg_q [NDIV+1];
  logic          dv_ovf_q [NDIV+1];
  ad_t           dv_ad_q  [NDIV+1];

  logic [69:0] num_mag;
  assign num_mag = (p4_num_q < 0) ? 70'(-p4_num_q) : 70'(p4_num_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_r_q[0]   <= num_mag;
      dv_d_q[0]   <= p4_den_q;
      dv_q_q[0]   <= '0;
      dv_neg_q[0] <= p4_num_q < 0;
      dv_ovf_q[0] <= num_mag >= {p4_den_q, 2'b00};
      dv_ad_q[0]  <= p4_ad_q;
    end
  end

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    logic [69:0] rin, dvs;
    logic        take;
    // integer bits first (against 2D, then D), then the fraction bits
    assign rin  = (j > 2) ? {dv_r_q[j-1][68:0], 1'b0} : dv_r_q[j-1];
    assign dvs  = (j == 1) ? {1'b0, dv_d_q[j-1], 1'b0} : {2'b00, dv_d_q[j-1]};
    assign take = rin >= dvs;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_r_q[j]   <= take ? rin - dvs : rin;
        dv_d_q[j]   <= dv_d_q[j-1];
        dv_q_q[j]   <= {dv_q_q[j-1][QW-2:0], take};
        dv_neg_q[j] <= dv_neg_q[j-1];
        dv_ovf_q[j] <= dv_ovf_q[j-1];
        dv_ad_q[j]  <= dv_ad_q[j-1];
      end
    end
  end

  // signed, saturated parameter t; the negative side rounds toward minus infinity
  logic [TW-1:0]        qc;
  logic signed [TW-1:0] t_d;
  logic signed [TW-1:0] t_q;
  ad_t                  t_ad_q;

  always_comb begin
    qc = TW'(dv_q_q[NDIV]) + TW'(dv_r_q[NDIV] != '0);
    if (dv_neg_q[NDIV]) begin
      if (dv_ovf_q[NDIV] || qc > LIM_N) begin
        t_d = $signed(TW'(0) - LIM_N);
      end else begin
        t_d = $signed(TW'(0) - qc);
      end
    end else begin
      if (dv_ovf_q[NDIV] || TW'(dv_q_q[NDIV]) > LIM_P) begin
        t_d = $signed(LIM_P);
      end else begin
        t_d = $signed(TW'(dv_q_q[NDIV]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_d;
      t_ad_q <= dv_ad_q[NDIV];
    end
  end

  logic signed [MW-1:0] m_x_q, m_y_q;
  ad_t                  m_ad_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_x_q  <= MW'(t_ad_q.dx) * MW'(t_q);
      m_y_q  <= MW'(t_ad_q.dy) * MW'(t_q);
      m_ad_q <= t_ad_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_x_o <= rsit_pkg::PW'(m_ad_q.ax)
             + m_x_q[FRACTION_BITS + rsit_pkg::PW - 1 : FRACTION_BITS];
      p_y_o <= rsit_pkg::PW'(m_ad_q.ay)
             + m_y_q[FRACTION_BITS + rsit_pkg::PW - 1 : FRACTION_BITS];
    end
  end

endmodule

[design/rsit_chk.sv]
module rsit_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rsit_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken during output stall");

  a_degen_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> !out_data_o.hit)
    else $error("degenerate result flagged as hit");

endmodule

bind rect_segment_intersect_test rsit_chk u_rsit_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[bench/tb_rect_segment_intersect_test.sv]
module tb_rect_segment_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 370;

  class contact_scoreboard;
    rsit_pkg::out_t expected_q[$];
    longint tol;
    int errors;

    function new();
      tol = 0;
      errors = 0;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v;
    endfunction

    function bit near_rect(longint px, longint py, longint l, longint r,
                           longint b, longint t);
      longint cx, cy, ex, ey;
      cx = clampl(px, l, r);
      cy = clampl(py, b, t);
      if (px == cx && py == cy) return 1'b1;
      ex = (px > cx) ? px - cx : cx - px;
      ey = (py > cy) ? py - cy : cy - py;
      if (ex > tol || ey > tol) return 1'b0;
      return (ex * ex + ey * ey) <= tol * tol;
    endfunction

    function bit in_span(longint e0, longint e1, longint p);
      longint lo, hi;
      lo = (e0 < e1) ? e0 : e1;
      hi = (e0 < e1) ? e1 : e0;
      return lo <= p && p <= hi;
    endfunction

    // project the corner onto A + D*t, t in fixed point rounded toward minus infinity
    function void project_corner(longint ax, longint ay, longint dx, longint dy,
                                 longint cx, longint cy,
                                 output longint px, output longint py);
      logic signed [127:0] sx, sy, wdx, wdy, num, den, q, rm;
      longint tq;
      sx = cx - ax;
      sy = cy - ay;
      wdx = dx;
      wdy = dy;
      num = sx * wdx + sy * wdy;
      den = wdx * wdx + wdy * wdy;
      if (num >= 0) begin
        q = (num <<< FRAC) / den;
        tq = (q > (128'sd1 <<< FRAC)) ? (64'sd1 <<< FRAC) : longint'(q);
      end else begin
        num = -num;
        q = (num <<< FRAC) / den;
        rm = (num <<< FRAC) % den;
        if (rm != 0) q = q + 1;
        tq = (q > (128'sd2 <<< FRAC)) ? -(64'sd2 <<< FRAC) : -longint'(q);
      end
      px = ax + ((dx * tq) >>> FRAC);
      py = ay + ((dy * tq) >>> FRAC);
    endfunction

    function void note_query(rsit_pkg::in_t q);
      longint l, b, r, t, ax, ay, bx, by, dx, dy;
      longint c1x, c1y, c2x, c2y, p1x, p1y, p2x, p2y;
      rsit_pkg::out_t res;
      l = longint'(q.rect_left_x);
      b = longint'(q.rect_bottom_y);
      r = l + longint'({1'b0, q.rect_width});
      t = b + longint'({1'b0, q.rect_height});
      ax = longint'(q.seg_a_x);
      ay = longint'(q.seg_a_y);
      bx = longint'(q.seg_b_x);
      by = longint'(q.seg_b_y);
      dx = ax - bx;
      dy = ay - by;
      res = '0;
      if (near_rect(ax, ay, l, r, b, t) || near_rect(bx, by, l, r, b, t)) begin
        res.hit = 1'b1;
      end else if (dx == 0 && dy == 0) begin
        res.degenerate = 1'b1;
      end else begin
        if ((dx > 0 && dy > 0) || (dx < 0 && dy < 0)) begin
          c1x = l; c1y = t; c2x = r; c2y = b;
        end else begin
          c1x = r; c1y = t; c2x = l; c2y = b;
        end
        project_corner(ax, ay, dx, dy, c1x, c1y, p1x, p1y);
        project_corner(ax, ay, dx, dy, c2x, c2y, p2x, p2y);
        res.hit = (near_rect(p1x, p1y, l, r, b, t) && in_span(ax, bx, p1x) &&
                   in_span(ay, by, p1y)) ||
                  (near_rect(p2x, p2y, l, r, b, t) && in_span(ax, bx, p2x) &&
                   in_span(ay, by, p2y));
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(rsit_pkg::out_t got);
      rsit_pkg::out_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual hit=%0b degenerate=%0b",
                 $time, got.hit, got.degenerate);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.hit !== exp_r.hit) begin
        $display("%0t: hit mismatch expected %0b actual %0b", $time, exp_r.hit, got.hit);
        errors++;
      end
      if (got.degenerate !== exp_r.degenerate) begin
        $display("%0t: degenerate mismatch expected %0b actual %0b",
                 $time, exp_r.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rsit_pkg::TOLW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  rsit_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsit_pkg::out_t out_data_o;

  contact_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;

  always #5 clk_i = ~clk_i;

  rect_segment_intersect_test u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_query(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver stall pattern: mode changes now and then
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((($time / 10) % 7) < 4);
    endcase
  end

  task automatic send_query(rsit_pkg::in_t q);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic gap(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_tolerance(logic [rsit_pkg::TOLW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    sb.tol = longint'({1'b0, v});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (2) @(negedge clk_i);
  endtask

  function automatic rsit_pkg::in_t make_query(longint lx, longint by, longint w, longint h,
                                               longint ax, longint ay, longint bx,
                                               longint bty);
    rsit_pkg::in_t q;
    q.rect_left_x = lx[31:0];
    q.rect_bottom_y = by[31:0];
    q.rect_width = w[30:0];
    q.rect_height = h[30:0];
    q.seg_a_x = ax[31:0];
    q.seg_a_y = ay[31:0];
    q.seg_b_x = bx[31:0];
    q.seg_b_y = bty[31:0];
    return q;
  endfunction

  function automatic longint near_coord(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic rsit_pkg::in_t random_query();
    rsit_pkg::in_t q;
    logic [255:0] raw;
    int kind;
    int span;
    kind = $urandom_range(0, 9);
    span = 1 << $urandom_range(4, 22);
    if (kind < 2) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q = raw[$bits(rsit_pkg::in_t)-1:0];
      if (q.rect_width == 0) q.rect_width = 1;
      if (q.rect_height == 0) q.rect_height = 1;
    end else begin
      q = make_query(near_coord(span), near_coord(span),
                     $urandom_range(1, span), $urandom_range(1, span),
                     near_coord(2 * span), near_coord(2 * span),
                     near_coord(2 * span), near_coord(2 * span));
      if (kind == 9) begin
        q.seg_b_x = q.seg_a_x;
        q.seg_b_y = q.seg_a_y;
      end else if (kind == 8) begin
        if ($urandom_range(0, 1)) q.seg_b_x = q.seg_a_x;
        else q.seg_b_y = q.seg_a_y;
      end
    end
    return q;
  endfunction

  task automatic run_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n > 0) begin
        send_query(random_query());
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 12));
    end
    gap(0);
  endtask

  initial begin
    logic [rsit_pkg::TOLW-1:0] tols[5];
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    set_tolerance('0);
    // extremes and zero tolerance
    send_query(make_query(-64'sd2147483648, -64'sd2147483648, 64'd2147483647, 64'd2147483647,
                          64'sd2147483647, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647));
    send_query(make_query(64'sd2147483647, 64'sd2147483647, 64'd2147483647, 64'd2147483647,
                          -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647));
    send_query(make_query(0, 0, 1, 1, 5, 5, 5, 5));           // zero length, away
    send_query(make_query(0, 0, 100, 100, 50, 50, 50, 50));   // zero length, inside
    send_query(make_query(0, 0, 100, 100, -50, 50, 150, 60)); // crosses, both ends out
    send_query(make_query(0, 0, 100, 100, -50, -40, 150, 160));
    send_query(make_query(0, 0, 100, 100, -50, 160, 150, -40));
    send_query(make_query(0, 0, 100, 100, 50, -40, 50, 160)); // vertical
    send_query(make_query(0, 0, 100, 100, -10, 120, 120, -10));
    send_query(make_query(0, 0, 100, 100, -10, 250, 250, -10)); // misses the corner
    send_query(make_query(0, 0, 100, 100, 100, 100, 300, 300)); // end on the corner
    send_query(make_query(0, 0, 100, 100, 101, 50, 300, 50));
    gap(3);
    drain();

    set_tolerance(31'h7FFFFFFF);
    send_query(make_query(-64'sd2147483648, -64'sd2147483648, 1, 1,
                          64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647));
    send_query(make_query(0, 0, 1, 1, 64'sd2147483647, -64'sd2147483648,
                          -64'sd2147483648, 64'sd2147483647));
    gap(0);
    drain();

    set_tolerance(31'd3);
    send_query(make_query(0, 0, 100, 100, 102, 102, 102, 102)); // within margin
    send_query(make_query(0, 0, 100, 100, 103, 103, 103, 103));
    send_query(make_query(0, 0, 100, 100, 104, 50, 104, 50));
    send_query(make_query(0, 0, 100, 100, 90, 115, 115, 90));
    send_query(make_query(0, 0, 100, 100, 96, 114, 114, 96));
    gap(0);
    drain();

    tols[0] = '0;
    tols[1] = 31'h7FFFFFFF;
    tols[2] = 31'($urandom_range(0, 1 << 18));
    tols[3] = 31'd1;
    tols[4] = 31'($urandom);
    foreach (tols[i]) begin
      set_tolerance(tols[i]);
      run_random(PHASE_ITEMS);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
